// ----- rtl/sorted_unique_event_time_set_core_macros.svh -----
// Assertion macros used by the checker file of the event time set core.
// Plain text macros only; no dependencies.
`ifndef SORTED_UNIQUE_EVENT_TIME_SET_CORE_MACROS_SVH
`define SORTED_UNIQUE_EVENT_TIME_SET_CORE_MACROS_SVH

// Check a property on every edge outside reset.
`define SUES_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every edge, reset included.
`define SUES_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/sues_pkg.sv -----
// Package of the sorted unique event time set core: widths, status codes
// and the control bundle broadcast to the cell chain. No dependencies.
package sues_pkg;

  localparam int SET_DEPTH_DEF = 64;
  localparam int TIME_W        = 31;
  localparam int COUNT_OUT_W   = 7;
  localparam int IN_DATA_W     = 32;
  localparam int OUT_DATA_W    = 48;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_DUP       = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Broadcast to every cell for one item
  typedef struct packed {
    logic              do_ins;
    logic              do_del;
    logic [TIME_W-1:0] tval;
  } ctrl_t;

endpackage

// ----- rtl/sues_cell.sv -----
// One slot of the sorted chain: compares its time with the broadcast value
// and takes its own, the new, or a neighbor's time. Uses sues_pkg.
module sues_cell import sues_pkg::*; #(
  parameter int CW  = 7,
  parameter int IDX = 0
) (
  input  logic              clk,
  input  ctrl_t             ctrl,
  input  logic [CW-1:0]     count,
  input  logic              left_lt,
  input  logic [TIME_W-1:0] left_val,
  input  logic [TIME_W-1:0] right_val,
  output logic              lt,
  output logic              eq,
  output logic [TIME_W-1:0] slot,
  output logic [TIME_W-1:0] slot_next
);

  logic valid;

  // Compare against the broadcast time; slots at or above count are empty
  assign valid = (CW'(IDX) < count);
  assign lt    = valid && (slot < ctrl.tval);
  assign eq    = valid && (slot == ctrl.tval);

  // Insert: open a gap at the first slot not below the new time.
  // Delete: close the gap from the matching slot upward.
  always_comb begin
    slot_next = slot;
    if (ctrl.do_ins && !lt) begin
      slot_next = left_lt ? ctrl.tval : left_val;
    end else if (ctrl.do_del && !lt) begin
      slot_next = right_val;
    end
  end

  always_ff @(posedge clk) begin
    slot <= slot_next;
  end

endmodule

// ----- rtl/sorted_unique_event_time_set_core.sv -----
// Top level of the sorted unique event time set: a chain of sues_cell slots,
// the element count and the result register. Uses sues_pkg and sues_cell.
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | s_tdata: command, time_value
//  m_*     | out | m_tvalid/m_tready  | m_tdata: status, earliest_time, held_count, is_empty
//
// One item per cycle while s_tready is high; its result is registered and shows on m_* in the cycle after.
// Every cell compares and shifts in parallel, so the rate does not depend on depth;
// the count and the OR over the equal flags set the path length.
// s_tready is low only while a result waits and m_tready is low.
// rst (synchronous) empties the set and drops any pending result.
module sorted_unique_event_time_set_core import sues_pkg::*; #(
  parameter int SET_DEPTH = SET_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,  // [0] command, [31:1] time_value
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata   // [1:0] status, [32:2] earliest_time,
                                          // [39:33] held_count, [40] is_empty, zero pad
);

  localparam int CW = $clog2(SET_DEPTH + 1);

  logic                  accept;
  logic                  command;
  logic [TIME_W-1:0]     time_value;
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic [SET_DEPTH-1:0]  lt_vec;
  logic [SET_DEPTH-1:0]  eq_vec;
  logic [TIME_W-1:0]     slot_q    [SET_DEPTH];
  logic [TIME_W-1:0]     slot_nx   [SET_DEPTH];
  logic                  present;
  logic                  full;
  status_t               status;
  ctrl_t                 ctrl;
  logic [TIME_W-1:0]     earliest_time;
  logic [OUT_DATA_W-1:0] m_tdata_next;

  assign s_tready   = !m_tvalid || m_tready;
  assign accept     = s_tvalid && s_tready;
  assign command    = s_tdata[0];
  assign time_value = s_tdata[TIME_W:1];

  // Classify the item against the held set
  assign present = |eq_vec;
  assign full    = (count == CW'(SET_DEPTH));

  always_comb begin
    ctrl.tval   = time_value;
    ctrl.do_ins = 1'b0;
    ctrl.do_del = 1'b0;
    count_next  = count;
    if (command) begin
      if (present) begin
        status      = ST_DONE;
        ctrl.do_del = accept;
      end else begin
        status = ST_NOT_FOUND;
      end
    end else begin
      if (present) begin
        status = ST_DUP;
      end else if (full) begin
        status = ST_FULL;
      end else begin
        status      = ST_DONE;
        ctrl.do_ins = accept;
      end
    end
    if (ctrl.do_ins) begin
      count_next = count + CW'(1);
    end else if (ctrl.do_del) begin
      count_next = count - CW'(1);
    end
  end

  // Chain of slots, each handing its time to its neighbors
  for (genvar i = 0; i < SET_DEPTH; i++) begin : g_cell
    logic              left_lt;
    logic [TIME_W-1:0] left_val;
    logic [TIME_W-1:0] right_val;

    if (i == 0) begin : g_first
      assign left_lt  = 1'b1;
      assign left_val = time_value;
    end else begin : g_mid
      assign left_lt  = lt_vec[i-1];
      assign left_val = slot_q[i-1];
    end

    if (i == SET_DEPTH - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_inner
      assign right_val = slot_q[i+1];
    end

    sues_cell #(
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .count     (count),
      .left_lt   (left_lt),
      .left_val  (left_val),
      .right_val (right_val),
      .lt        (lt_vec[i]),
      .eq        (eq_vec[i]),
      .slot      (slot_q[i]),
      .slot_next (slot_nx[i])
    );
  end

  // Hold the element count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Build the result from the state after this item
  assign earliest_time = (count_next != '0) ? slot_nx[0] : '0;
  assign m_tdata_next  = {{(OUT_DATA_W - 41){1'b0}},
                          (count_next == '0),
                          COUNT_OUT_W'(count_next),
                          earliest_time,
                          status};

  // Result register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= m_tdata_next;
    end
  end

endmodule

// ----- rtl/sues_checker.sv -----
// Port-level checks for the sorted unique event time set core, bound to the
// top level. Uses sues_pkg and the shared assertion macros.
`include "sorted_unique_event_time_set_core_macros.svh"

module sues_checker import sues_pkg::*; #(
  parameter int SET_DEPTH = SET_DEPTH_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  // A stalled result keeps its payload
  `SUES_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

  // An empty set reports a zero count and a zero earliest time
  `SUES_ASSERT(a_empty, m_tvalid && m_tdata[40] |-> m_tdata[39:33] == '0 && m_tdata[32:2] == '0, "empty result inconsistent")

  // A full report comes only with a full count
  `SUES_ASSERT(a_full, m_tvalid && m_tdata[1:0] == ST_FULL |-> m_tdata[39:33] == COUNT_OUT_W'(SET_DEPTH), "full status with spare room")

  // After reset the input side is open and no result is pending
  `SUES_ASSERT_ALWAYS(a_reset, rst |=> s_tready && !m_tvalid, "not idle after reset")

endmodule

bind sorted_unique_event_time_set_core sues_checker #(
  .SET_DEPTH (SET_DEPTH)
) u_sues_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- tb/tb_top.sv -----
// Testbench of the sorted unique event time set core: directed and random
// insert/delete items checked against a predictor of the sorted time set.
// Depends on sues_pkg and sorted_unique_event_time_set_core.
`timescale 1ns / 1ps

module tb_top;
  import sues_pkg::*;

  localparam int SET_DEPTH   = SET_DEPTH_DEF;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 10;
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // One result of the set, as the block reports it
  typedef struct packed {
    status_t                status;
    logic [TIME_W-1:0]      earliest;
    logic [COUNT_OUT_W-1:0] count;
    logic                   empty;
  } set_report_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // [0] command, [31:1] time_value
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // [1:0] status, [32:2] earliest_time,
                                         // [39:33] held_count, [40] is_empty

  // Predicted contents of the set, ascending
  logic [TIME_W-1:0] held_times [SET_DEPTH];
  int                held_n = 0;
  set_report_t       awaited_reports [$];

  int errors = 0;
  int burst_left = 0;
  bit no_gaps = 1'b0;
  bit hold_pending = 1'b0;
  int hold_left = 0;
  int rx_cycle = 0;

  sorted_unique_event_time_set_core #(.SET_DEPTH(SET_DEPTH)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  // Apply one command to the predicted set and return the report it causes
  function automatic set_report_t update_time_set(logic cmd, logic [TIME_W-1:0] tv);
    set_report_t r;
    int pos;
    bit found;
    pos = 0;
    while (pos < held_n && held_times[pos] < tv) pos++;
    found = (pos < held_n) && (held_times[pos] == tv);
    if (cmd == CMD_INSERT) begin
      if (found) begin
        r.status = ST_DUP;
      end else if (held_n >= SET_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        for (int k = held_n; k > pos; k--) held_times[k] = held_times[k-1];
        held_times[pos] = tv;
        held_n++;
        r.status = ST_DONE;
      end
    end else begin
      if (!found) begin
        r.status = ST_NOT_FOUND;
      end else begin
        for (int k = pos; k + 1 < held_n; k++) held_times[k] = held_times[k+1];
        held_n--;
        r.status = ST_DONE;
      end
    end
    r.earliest = (held_n > 0) ? held_times[0] : '0;
    r.count    = COUNT_OUT_W'(held_n);
    r.empty    = (held_n == 0);
    return r;
  endfunction

  // Offer one item, wait for its handshake, then record its expected report.
  // Must be called right after a rising edge.
  task automatic send_item(input logic cmd, input logic [TIME_W-1:0] tv);
    int gap;
    if (burst_left == 0) begin
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {tv, cmd};
    do @(posedge clk); while (!s_tready);
    awaited_reports.push_back(update_time_set(cmd, tv));
  endtask

  // Time value biased toward held entries, a small pool and the top of range
  function automatic logic [TIME_W-1:0] pick_time(int pool);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4 && held_n > 0) return held_times[$urandom_range(0, held_n - 1)];
    if (sel < 8) return TIME_W'($urandom_range(0, pool));
    if (sel == 8) return TIME_MAX - TIME_W'($urandom_range(0, pool));
    return TIME_W'($urandom);
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $realtime, name, want, got);
      errors++;
    end
  endtask

  // Compare each accepted result with the oldest expected report
  always @(posedge clk) begin
    set_report_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_reports.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $realtime, m_tdata);
        errors++;
      end else begin
        want = awaited_reports.pop_front();
        check_field("status", 32'(want.status), 32'(m_tdata[1:0]));
        check_field("earliest_time", 32'(want.earliest), 32'(m_tdata[32:2]));
        check_field("held_count", 32'(want.count), 32'(m_tdata[39:33]));
        check_field("is_empty", 32'(want.empty), 32'(m_tdata[40]));
        check_field("pad", 0, 32'(m_tdata[OUT_DATA_W-1:41]));
      end
    end
  end

  // Receiver: a long hold-off on request, otherwise a rotating stall pattern
  always @(posedge clk) begin
    rx_cycle++;
    if (hold_pending) begin
      hold_pending = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      case ((rx_cycle / 50) % 4)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= (rx_cycle % 3 != 0);
      endcase
    end
  end

  // Extremes of the time field, duplicates and absent deletes
  task automatic test_directed();
    send_item(CMD_DELETE, '0);
    send_item(CMD_INSERT, TIME_MAX);
    send_item(CMD_INSERT, '0);
    send_item(CMD_INSERT, '0);
    send_item(CMD_INSERT, TIME_MAX);
    send_item(CMD_INSERT, 31'h2AAA_AAAA);
    send_item(CMD_INSERT, 31'h5555_5555);
    send_item(CMD_DELETE, 31'h2AAA_AAAB);
    send_item(CMD_DELETE, 31'h2AAA_AAAA);
    send_item(CMD_DELETE, '0);
    send_item(CMD_INSERT, 31'd1);
    send_item(CMD_DELETE, TIME_MAX);
    send_item(CMD_DELETE, TIME_MAX);
    send_item(CMD_DELETE, 31'h5555_5555);
    send_item(CMD_DELETE, 31'd1);
    send_item(CMD_DELETE, 31'd1);
    send_item(CMD_INSERT, TIME_MAX - TIME_W'(1));
    send_item(CMD_DELETE, TIME_MAX - TIME_W'(1));
  endtask

  // Fill the store, try a new time, duplicates and a delete at full, then empty it
  task automatic test_full_store();
    logic [TIME_W-1:0] base;
    logic [TIME_W-1:0] step;
    base = TIME_W'($urandom_range(0, 1000));
    step = TIME_W'($urandom_range(1, 7));
    for (int i = 0; i < SET_DEPTH; i++)
      send_item(CMD_INSERT, base + step * TIME_W'((i * 37) % SET_DEPTH));
    send_item(CMD_INSERT, base + step * TIME_W'(SET_DEPTH));
    send_item(CMD_INSERT, base);
    send_item(CMD_INSERT, base + step * TIME_W'(SET_DEPTH - 1));
    send_item(CMD_DELETE, base + step * TIME_W'(5));
    send_item(CMD_INSERT, TIME_MAX);
    send_item(CMD_INSERT, '0);
    while (held_n > 0) send_item(CMD_DELETE, held_times[$urandom_range(0, held_n - 1)]);
    send_item(CMD_DELETE, base);
  endtask

  // Random churn with a chosen insert share and value pool
  task automatic test_random_churn(input int n, input int insert_pct, input int pool);
    logic cmd;
    for (int i = 0; i < n; i++) begin
      cmd = ($urandom_range(1, 100) <= insert_pct) ? CMD_INSERT : CMD_DELETE;
      send_item(cmd, pick_time(pool));
    end
  endtask

  // Receiver holds off while the sender keeps offering back to back
  task automatic test_backpressure();
    no_gaps = 1'b1;
    burst_left = 0;
    hold_pending = 1'b1;
    test_random_churn(40, 60, 50);
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_store();
    test_random_churn(180, 75, 120);
    test_backpressure();
    test_random_churn(200, 30, 120);
    test_random_churn(180, 50, 300);
    test_random_churn(100, 65, 70);
    s_tvalid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
